// ----- src/rdc_pkg.sv -----
`default_nettype none

package rdc_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_DIGITS_DEF = 11;

    localparam int VALUE_W = 32;
    localparam int RADIX_W = 2;
    localparam int CHAR_W  = 7;
    localparam int DIGIT_W = 4;

    typedef enum logic [RADIX_W-1:0] {
        RADIX_OCT = 2'd0,
        RADIX_DEC = 2'd1,
        RADIX_HEX = 2'd2
    } radix_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
    } out_item_t;

    typedef enum logic [1:0] {
        STEP_WAIT = 2'd0,
        STEP_DIV  = 2'd1,
        STEP_PUSH = 2'd2,
        STEP_EMIT = 2'd3
    } step_t;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_DIV  = 2'd1,
        OP_PUSH = 2'd2,
        OP_EMIT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        COND_START    = 2'd0,
        COND_DIV_DONE = 2'd1,
        COND_MORE     = 2'd2,
        COND_LAST     = 2'd3
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jump;
        step_t next;
    } ctrl_word_t;

    // Control store: each step names its datapath operation, the condition
    // it tests, where to go when the condition holds and where otherwise.
    function automatic ctrl_word_t microcode(step_t s);
        ctrl_word_t w;
        unique case (s)
            STEP_WAIT: w = '{op: OP_LOAD, cond: COND_START,    jump: STEP_DIV,  next: STEP_WAIT};
            STEP_DIV:  w = '{op: OP_DIV,  cond: COND_DIV_DONE, jump: STEP_PUSH, next: STEP_DIV};
            STEP_PUSH: w = '{op: OP_PUSH, cond: COND_MORE,     jump: STEP_DIV,  next: STEP_EMIT};
            STEP_EMIT: w = '{op: OP_EMIT, cond: COND_LAST,     jump: STEP_WAIT, next: STEP_EMIT};
            default:   w = '{op: OP_LOAD, cond: COND_START,    jump: STEP_DIV,  next: STEP_WAIT};
        endcase
        return w;
    endfunction

    function automatic logic [CHAR_W-1:0] glyph(logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10)
        begin
            c = 7'd48 + {3'b000, d};
        end
        else
        begin
            c = 7'd55 + {3'b000, d};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/radix_digit_converter.sv -----
// Channel   Handshake        Payload                      Direction
// input     start / busy     operand (value, radix)       into the block
// result    strobe           result (digit_char, last)    out of the block
//
// An item is taken when start is high and busy is low; radix code 3 is dropped.
// Each digit takes divide steps and then a push step: octal and hexadecimal need one divide step,
// decimal one for each 8-bit chunk of VALUE_BITS, in the 8-bit-per-cycle divide-by-ten unit.
// Emission then pops the digits from the stack, most significant first.
// Reset clears the step counter, the chunk counter, the digit count and the result strobe.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

module radix_digit_converter #(
    parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEF
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    output logic              busy,
    input  rdc_pkg::in_item_t operand,
    output logic              strobe,
    output rdc_pkg::out_item_t result
);
    import rdc_pkg::*;

    localparam int CHUNK    = 8;
    localparam int NCHUNK   = (VALUE_BITS + CHUNK - 1) / CHUNK;
    localparam int DIV_BITS = NCHUNK * CHUNK;
    localparam int CHK_W    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int CNT_W    = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W    = $clog2(MAX_DIGITS);

    step_t                step_reg, step_next;
    logic [DIV_BITS-1:0]  work_reg, work_next;
    logic [DIGIT_W-1:0]   rem_reg, rem_next;
    logic [CHK_W-1:0]     chunk_reg, chunk_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [RADIX_W-1:0]   radix_reg, radix_next;
    logic [DIGIT_W-1:0]   stack_reg [MAX_DIGITS];
    logic                 strobe_reg, strobe_next;
    out_item_t            result_reg, result_next;

    ctrl_word_t           ctrl;
    logic                 cond_hit;
    logic                 radix_ok;
    logic                 pow2;
    logic [DIV_BITS-1:0]  value_ext;
    logic [CNT_W-1:0]     emit_cnt;
    logic [DIGIT_W-1:0]   emit_digit;
    logic                 push_en;

    generate
        if (VALUE_BITS >= VALUE_W)
        begin : g_ext_wide
            assign value_ext = DIV_BITS'(operand.value);
        end
        else
        begin : g_ext_narrow
            assign value_ext = DIV_BITS'(operand.value[VALUE_BITS-1:0]);
        end
    endgenerate

    assign ctrl       = microcode(step_reg);
    assign radix_ok   = (operand.radix == RADIX_OCT) || (operand.radix == RADIX_DEC) ||
                        (operand.radix == RADIX_HEX);
    assign pow2       = (radix_reg != RADIX_DEC);
    assign emit_cnt   = cnt_reg - CNT_W'(1);
    assign emit_digit = stack_reg[emit_cnt[IDX_W-1:0]];
    assign busy       = (step_reg != STEP_WAIT);
    assign strobe     = strobe_reg;
    assign result     = result_reg;

    always_comb
    begin
        unique case (ctrl.cond)
            COND_START:    cond_hit = start && radix_ok;
            COND_DIV_DONE: cond_hit = pow2 || (chunk_reg == CHK_W'(NCHUNK - 1));
            COND_MORE:     cond_hit = (work_reg != '0) && (cnt_reg < CNT_W'(MAX_DIGITS - 1));
            COND_LAST:     cond_hit = (cnt_reg == CNT_W'(1));
            default:       cond_hit = 1'b0;
        endcase
        step_next = cond_hit ? ctrl.jump : ctrl.next;
    end

    always_comb
    begin
        logic [DIGIT_W:0]   r;
        logic [CHUNK-1:0]   q;
        work_next   = work_reg;
        rem_next    = rem_reg;
        chunk_next  = chunk_reg;
        cnt_next    = cnt_reg;
        radix_next  = radix_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        push_en     = 1'b0;
        r           = '0;
        q           = '0;
        unique case (ctrl.op)
            OP_LOAD:
            begin
                if (start && radix_ok)
                begin
                    work_next  = value_ext;
                    rem_next   = '0;
                    chunk_next = '0;
                    cnt_next   = '0;
                    radix_next = operand.radix;
                end
            end
            OP_DIV:
            begin
                case (radix_reg)
                    RADIX_OCT:
                    begin
                        rem_next  = {1'b0, work_reg[2:0]};
                        work_next = work_reg >> 3;
                    end
                    RADIX_HEX:
                    begin
                        rem_next  = work_reg[3:0];
                        work_next = work_reg >> 4;
                    end
                    default:
                    begin
                        // Restoring division by ten, most significant bits first.
                        r = {1'b0, rem_reg};
                        for (int i = 0; i < CHUNK; i++)
                        begin
                            r = {r[DIGIT_W-1:0], work_reg[DIV_BITS-1-i]};
                            if (r >= 5'd10)
                            begin
                                r = r - 5'd10;
                                q[CHUNK-1-i] = 1'b1;
                            end
                        end
                        rem_next   = r[DIGIT_W-1:0];
                        work_next  = (work_reg << CHUNK) | DIV_BITS'(q);
                        chunk_next = chunk_reg + CHK_W'(1);
                    end
                endcase
            end
            OP_PUSH:
            begin
                push_en    = 1'b1;
                cnt_next   = cnt_reg + CNT_W'(1);
                rem_next   = '0;
                chunk_next = '0;
            end
            OP_EMIT:
            begin
                strobe_next            = 1'b1;
                result_next.digit_char = glyph(emit_digit);
                result_next.last       = (cnt_reg == CNT_W'(1));
                cnt_next               = emit_cnt;
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= STEP_WAIT;
            cnt_reg    <= '0;
            chunk_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            step_reg   <= step_next;
            cnt_reg    <= cnt_next;
            chunk_reg  <= chunk_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg   <= work_next;
        rem_reg    <= rem_next;
        radix_reg  <= radix_next;
        result_reg <= result_next;
        if (push_en)
        begin
            stack_reg[cnt_reg[IDX_W-1:0]] <= rem_reg;
        end
    end

`ifndef SYNTHESIS
    a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(step_reg == STEP_EMIT))
        else $error("result strobe without an emit step");

    a_last_frees_block: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && result_reg.last) |-> !busy)
        else $error("block still busy after the last digit");

    a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_EMIT) |-> (cnt_reg != '0))
        else $error("emit step with an empty digit stack");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_DIGITS))
        else $error("digit count beyond the stack depth");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> ((result_reg.digit_char >= 7'd48 && result_reg.digit_char <= 7'd57) ||
                        (result_reg.digit_char >= 7'd65 && result_reg.digit_char <= 7'd70)))
        else $error("digit character out of range");
`endif

endmodule

`default_nettype wire
